@@ rtl/lkvc_pkg.sv @@
// Shared types and constants for the least-recently-used key-value cache.
// Depends on nothing; every other file of the block refers to it by scoped names.
package lkvc_pkg;

  localparam int unsigned ENTRIES   = 16;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned FILL_W    = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W     = (FILL_W > CFG_W) ? FILL_W : CFG_W;
  localparam int unsigned CAP_RESET = 16;

  // Request codes carried on the command field.
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // One stored entry as it moves along the recency chain.
  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
  } entry_t;

endpackage

@@ rtl/lru_key_value_cache.sv @@
// Top level of the fully associative key-value cache with LRU replacement.
// Depends on lkvc_pkg and instantiates one lkvc_cell per entry.

// The cache keeps its entries in a chain of cells ordered by recency: cell 0
// holds the most recently used entry and each further cell an older one, so
// the least recent valid entry always sits at the end of the filled region.
// Every request compares its key against all cells at once. A get that hits
// returns the stored value with hit set and moves that entry to the head; a
// get that misses returns hit clear and a value of all ones and changes
// nothing. A put that hits rewrites the value and moves the entry to the head;
// a put that misses inserts at the head, pushing the filled region one cell
// down, and when the number of entries in use has reached the capacity the
// oldest entry falls off the end of that region. Moving to the head is done by
// every cell from the head down to the chosen position loading its upper
// neighbor in the same cycle. A transfer on the input is taken at every clock
// edge at which the result register is empty or is being emptied, so the block
// sustains one request per cycle, and the only thing that holds the input off
// is a stall on the output. The capacity register resets to 16; a value of 0
// acts as 1 and values above the number of entries act as the number of
// entries. Lowering the capacity evicts nothing at once; later put misses
// replace the oldest entry, and the count of entries in use never goes down.
// Reset clears all valid bits immediately; no clearing pass runs.
module lru_key_value_cache (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Capacity register write.
  input  logic                              cfg_we_i,
  input  logic [lkvc_pkg::CFG_W-1:0]        cfg_wdata_i,
  // Request channel.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              cmd_i,
  input  logic signed [lkvc_pkg::KEY_W-1:0] lookup_key_i,
  input  logic signed [lkvc_pkg::DATA_W-1:0] write_value_i,
  // Result channel.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              hit_o,
  output logic signed [lkvc_pkg::DATA_W-1:0] read_value_o
);

  // Capacity register.
  logic [lkvc_pkg::CFG_W-1:0] cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CFG_W'(lkvc_pkg::CAP_RESET);
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Effective capacity, clamped to the range one to the number of entries.
  logic [lkvc_pkg::CMP_W-1:0] cap_ext;
  logic [lkvc_pkg::CMP_W-1:0] cap_eff;

  always_comb begin
    cap_ext = lkvc_pkg::CMP_W'(cap_q);
    if (cap_ext == '0) begin
      cap_eff = lkvc_pkg::CMP_W'(1);
    end else if (cap_ext > lkvc_pkg::CMP_W'(lkvc_pkg::ENTRIES)) begin
      cap_eff = lkvc_pkg::CMP_W'(lkvc_pkg::ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  // Handshakes. The result register frees up in the same cycle it is taken.
  logic out_valid_q;
  logic accept;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Cell chain.
  lkvc_pkg::entry_t           cell_entry [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::ENTRIES-1:0] cell_match;
  logic [lkvc_pkg::ENTRIES-1:0] shift_en;
  lkvc_pkg::entry_t           head;
  logic [lkvc_pkg::KEY_W-1:0] req_key;

  assign req_key = $unsigned(lookup_key_i);

  for (genvar g = 0; g < lkvc_pkg::ENTRIES; g++) begin : g_cell
    lkvc_pkg::entry_t prev;
    if (g == 0) begin : g_head
      assign prev = head;
    end else begin : g_link
      assign prev = cell_entry[g-1];
    end

    lkvc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_en_i (shift_en[g]),
      .prev_i     (prev),
      .cmp_key_i  (req_key),
      .entry_o    (cell_entry[g]),
      .match_o    (cell_match[g])
    );
  end

  // Hit position and value. Valid keys are distinct, so at most one cell
  // matches and the value can be gathered with an OR.
  logic                        hit;
  logic [lkvc_pkg::IDX_W-1:0]  hit_idx;
  logic [lkvc_pkg::DATA_W-1:0] hit_value;

  always_comb begin
    hit_idx   = '0;
    hit_value = '0;
    for (int i = lkvc_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (cell_match[i]) begin
        hit_idx = lkvc_pkg::IDX_W'(i);
      end
      hit_value = hit_value | (cell_match[i] ? cell_entry[i].value : '0);
    end
    hit = |cell_match;
  end

  // Fill count and the position down to which the chain moves.
  logic [lkvc_pkg::FILL_W-1:0] fill_q, fill_d;
  logic [lkvc_pkg::CMP_W-1:0]  fill_ext;
  logic                        is_put;
  logic                        full;
  logic                        update;
  logic [lkvc_pkg::IDX_W-1:0]  shift_pt;

  always_comb begin
    is_put   = (cmd_i == lkvc_pkg::CMD_PUT);
    fill_ext = lkvc_pkg::CMP_W'(fill_q);
    full     = (fill_ext >= cap_eff);
    update   = accept && (hit || is_put);

    if (hit) begin
      shift_pt = hit_idx;
    end else if (full) begin
      // The oldest valid entry is the last one of the filled region.
      shift_pt = lkvc_pkg::IDX_W'(fill_q - lkvc_pkg::FILL_W'(1));
    end else begin
      shift_pt = lkvc_pkg::IDX_W'(fill_q);
    end

    fill_d = fill_q;
    if (accept && is_put && !hit && !full) begin
      fill_d = fill_q + lkvc_pkg::FILL_W'(1);
    end

    head.valid = 1'b1;
    head.key   = req_key;
    head.value = is_put ? $unsigned(write_value_i) : hit_value;
  end

  for (genvar g = 0; g < lkvc_pkg::ENTRIES; g++) begin : g_shift
    assign shift_en[g] = update && (shift_pt >= lkvc_pkg::IDX_W'(g));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Result register.
  logic                        out_valid_d;
  logic                        hit_q;
  logic [lkvc_pkg::DATA_W-1:0] read_value_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hit_q        <= hit;
      read_value_q <= (hit && !is_put) ? hit_value : '1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign read_value_o = $signed(read_value_q);

endmodule

@@ rtl/lkvc_cell.sv @@
// One position of the recency chain: holds an entry and compares its key.
// Depends on lkvc_pkg for the entry type and widths.
module lkvc_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       shift_en_i,
  input  lkvc_pkg::entry_t           prev_i,
  input  logic [lkvc_pkg::KEY_W-1:0] cmp_key_i,
  output lkvc_pkg::entry_t           entry_o,
  output logic                       match_o
);

  logic                        valid_q, valid_d;
  logic [lkvc_pkg::KEY_W-1:0]  key_q, key_d;
  logic [lkvc_pkg::DATA_W-1:0] value_q, value_d;

  always_comb begin
    valid_d = shift_en_i ? prev_i.valid : valid_q;
    key_d   = shift_en_i ? prev_i.key   : key_q;
    value_d = shift_en_i ? prev_i.value : value_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // The payload is only ever looked at where the valid bit is set.
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign entry_o.valid = valid_q;
  assign entry_o.key   = key_q;
  assign entry_o.value = value_q;
  assign match_o       = valid_q && (key_q == cmp_key_i);

endmodule
